### hw/rtl/qda_pkg.sv
// Shared types and constants for the QDA classifier inference block.
// No dependencies.
package qda_pkg;

    localparam int VAL_W = 32;
    localparam int ACC_W = 64;

    // Store sizes, fixed by the 4-bit class and 3-bit row/column fields
    localparam int MAX_CLASSES  = 16;
    localparam int MAX_FEATURES = 8;

    localparam logic [2:0] OP_MEAN   = 3'd0;
    localparam logic [2:0] OP_INVCOV = 3'd1;
    localparam logic [2:0] OP_LOGSZ  = 3'd2;
    localparam logic [2:0] OP_LOGDET = 3'd3;
    localparam logic [2:0] OP_TRAIN  = 3'd4;
    localparam logic [2:0] OP_QUERY  = 3'd5;
    // Unassigned opcodes: accepted and dropped
    localparam logic [2:0] OP_RSVD0  = 3'd6;
    localparam logic [2:0] OP_RSVD1  = 3'd7;

    localparam logic [1:0] CFG_MODE     = 2'd0;
    localparam logic [1:0] CFG_CLASSES  = 2'd1;
    localparam logic [1:0] CFG_FEATURES = 2'd2;

    localparam logic [1:0] MODE_FULL    = 2'd0;
    localparam logic [1:0] MODE_UNIFORM = 2'd1;
    localparam logic [1:0] MODE_MAHAL   = 2'd2;

    // Saturate a 64-bit signed value to the signed 32-bit range.
    function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi)
            sat32 = 32'sh7fffffff;
        else if (v < lo)
            sat32 = 32'sh80000000;
        else
            sat32 = v[VAL_W-1:0];
    endfunction

endpackage

### hw/rtl/qda_mac.sv
// Shared signed 32x32 multiplier with floor shift by 16, registered output.
// Depends on qda_pkg.
module qda_mac (
    input  logic                        clk,
    input  logic signed [qda_pkg::VAL_W-1:0] a,
    input  logic signed [qda_pkg::VAL_W-1:0] b,
    output logic signed [qda_pkg::ACC_W-1:0] prod
);
    import qda_pkg::*;

    logic signed [ACC_W-1:0] full_next;
    logic signed [ACC_W-1:0] prod_reg;

    // Arithmetic shift gives floor division by 2^16
    always_comb
    begin
        full_next = (ACC_W'(a) * ACC_W'(b)) >>> 16;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= full_next;
    end

    assign prod = prod_reg;
endmodule

### hw/rtl/qda_classifier_inference.sv
// QDA classifier inference: loads class parameters and scores a buffered query
// one class at a time through a single shared multiplier. Loads and query
// elements without the last flag are accepted while idle. A query item with the
// last flag runs the scoring sequencer: per trained class it forms the centered
// vector, passes each matrix row through the multiplier and memory read pipe,
// then forms and compares the criterion; each untrained class gets only the
// compare step, and a last step hands the result to the output register;
// in_ready is low during scoring and while a finished result waits for a still
// occupied output register. The shared multiplier and the single-read parameter
// memories set the length of the scoring sequence.
module qda_classifier_inference (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic [3:0]  class_id,
    input  logic [2:0]  row_index,
    input  logic [2:0]  col_index,
    input  logic signed [31:0] value,
    input  logic        last_element,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  best_class,
    output logic        any_trained
);
    import qda_pkg::*;

    localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CNW = $clog2(MAX_CLASSES + 1);
    localparam int FNW = $clog2(MAX_FEATURES + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_DIFF  = 10'b0000000010,  // read mean and query, form d
        S_DWAIT = 10'b0000000100,
        S_MROW  = 10'b0000001000,  // issue A(i,j)*d(j)
        S_MWAIT = 10'b0000010000,
        S_TSUM  = 10'b0000100000,  // issue d(i)*t(i)
        S_TWAIT = 10'b0001000000,
        S_CRIT  = 10'b0010000000,
        S_CMP   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } state_t;

    // Configuration
    logic [1:0] mode_reg;
    logic [4:0] ncls_reg;
    logic [3:0] nfeat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_FULL;
            ncls_reg  <= 5'd2;
            nfeat_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MODE:     mode_reg  <= cfg_data[1:0];
                CFG_CLASSES:  ncls_reg  <= cfg_data;
                CFG_FEATURES: nfeat_reg <= cfg_data[3:0];
                default:      ;
            endcase
        end
    end

    // Clamped counts
    logic [CNW-1:0] nc;
    logic [FNW-1:0] nf;
    always_comb
    begin
        if (ncls_reg == 5'd0)
            nc = CNW'(1);
        else if (32'(ncls_reg) > MAX_CLASSES)
            nc = CNW'(MAX_CLASSES);
        else
            nc = CNW'(ncls_reg);
        if (nfeat_reg == 4'd0)
            nf = FNW'(1);
        else if (32'(nfeat_reg) > MAX_FEATURES)
            nf = FNW'(MAX_FEATURES);
        else
            nf = FNW'(nfeat_reg);
    end

    // Memories
    logic signed [31:0] mean_mem [MAX_CLASSES*MAX_FEATURES];
    logic signed [31:0] cov_mem  [MAX_CLASSES*MAX_FEATURES*MAX_FEATURES];
    logic signed [31:0] lsz_mem  [MAX_CLASSES];
    logic signed [31:0] ldet_mem [MAX_CLASSES];
    logic signed [31:0] qry_mem  [MAX_FEATURES];
    logic signed [31:0] d_reg    [MAX_FEATURES];
    logic [MAX_CLASSES-1:0] trained_reg;

    state_t state_reg, state_next;
    logic [CW-1:0] cls_reg;
    logic [FW-1:0] i_reg, j_reg;
    logic signed [ACC_W-1:0] tacc_reg, dist_reg, best_crit_reg, crit_reg;
    logic [CW-1:0] best_reg;
    logic found_reg;

    // Output register
    logic       out_valid_reg;
    logic [3:0] out_class_reg;
    logic       out_found_reg;
    logic       out_load;

    logic accept;
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    logic cls_ok, row_ok, col_ok;
    assign cls_ok = 32'(class_id) < MAX_CLASSES;
    assign row_ok = 32'(row_index) < MAX_FEATURES;
    assign col_ok = 32'(col_index) < MAX_FEATURES;

    logic [CW-1:0] wcls;
    logic [FW-1:0] wrow, wcol;
    assign wcls = CW'(class_id);
    assign wrow = FW'(row_index);
    assign wcol = FW'(col_index);

    // Parameter writes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (op == OP_MEAN && cls_ok && row_ok)
                mean_mem[{wcls, wrow}] <= value;
            if (op == OP_INVCOV && cls_ok && row_ok && col_ok)
                cov_mem[{wcls, wrow, wcol}] <= value;
            if (op == OP_LOGSZ && cls_ok)
                lsz_mem[wcls] <= value;
            if (op == OP_LOGDET && cls_ok)
                ldet_mem[wcls] <= value;
            if (op == OP_QUERY && row_ok)
                qry_mem[wrow] <= value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            trained_reg <= '0;
        else if (accept && op == OP_TRAIN && cls_ok)
            trained_reg[wcls] <= (value != 32'sd0);
    end

    // Registered memory reads
    logic signed [31:0] mean_rd, qry_rd, cov_rd, lsz_rd, ldet_rd;
    always_ff @(posedge clk)
    begin
        mean_rd <= mean_mem[{cls_reg, i_reg}];
        qry_rd  <= qry_mem[i_reg];
        cov_rd  <= cov_mem[{cls_reg, i_reg, j_reg}];
        lsz_rd  <= lsz_mem[cls_reg];
        ldet_rd <= ldet_mem[cls_reg];
    end

    // Shared multiplier operands
    logic signed [31:0] mul_a, mul_b;
    logic signed [ACC_W-1:0] prod;
    always_comb
    begin
        if (state_reg == S_MWAIT)
        begin
            mul_a = cov_rd;
            mul_b = d_reg[j_reg];
        end
        else
        begin
            mul_a = d_reg[i_reg];
            mul_b = sat32(tacc_reg);
        end
    end

    qda_mac u_mac (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    logic last_i, last_j, last_c;
    assign last_i = (FNW'(i_reg) == nf - FNW'(1));
    assign last_j = (FNW'(j_reg) == nf - FNW'(1));
    assign last_c = (CNW'(cls_reg) == nc - CNW'(1));

    // Sub-phase flag: steps through the wait for the read and for the multiply
    logic ph_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cls_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            ph_reg    <= 1'b0;
            found_reg <= 1'b0;
            best_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    cls_reg   <= '0;
                    i_reg     <= '0;
                    j_reg     <= '0;
                    ph_reg    <= 1'b0;
                    found_reg <= 1'b0;
                    best_reg  <= '0;
                end
                S_DIFF:
                    ;
                S_DWAIT:
                begin
                    d_reg[i_reg] <= sat32(ACC_W'(qry_rd) - ACC_W'(mean_rd));
                    i_reg <= last_i ? '0 : i_reg + FW'(1);
                end
                S_MROW:
                begin
                    ph_reg <= 1'b0;
                    if (j_reg == '0)
                        tacc_reg <= '0;
                end
                S_MWAIT:
                begin
                    // ph low: operands go into multiplier; ph high: accumulate
                    ph_reg <= ~ph_reg;
                    if (ph_reg)
                    begin
                        tacc_reg <= tacc_reg + prod;
                        j_reg <= last_j ? '0 : j_reg + FW'(1);
                    end
                end
                S_TSUM:
                begin
                    ph_reg <= 1'b0;
                    if (i_reg == '0)
                        dist_reg <= '0;
                end
                S_TWAIT:
                begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg)
                    begin
                        dist_reg <= dist_reg + prod;
                        i_reg <= last_i ? '0 : i_reg + FW'(1);
                    end
                end
                S_CRIT:
                begin
                    unique case (mode_reg)
                        MODE_FULL:    crit_reg <= ACC_W'(lsz_rd) - ACC_W'(ldet_rd) - dist_reg;
                        MODE_UNIFORM: crit_reg <= -ACC_W'(ldet_rd) - dist_reg;
                        MODE_MAHAL:   crit_reg <= -dist_reg;
                        default:      crit_reg <= '0;
                    endcase
                end
                S_CMP:
                begin
                    if (trained_reg[cls_reg] && (!found_reg || crit_reg > best_crit_reg))
                    begin
                        found_reg     <= 1'b1;
                        best_reg      <= cls_reg;
                        best_crit_reg <= crit_reg;
                    end
                    if (!last_c)
                        cls_reg <= cls_reg + CW'(1);
                    i_reg <= '0;
                    j_reg <= '0;
                end
                S_OUT:
                    ;
                default:
                    ;
            endcase
        end
    end

    // Result moves to the output register once that register is free
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_class_reg <= 4'd0;
            out_found_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
            out_class_reg <= 4'(best_reg);
            out_found_reg <= found_reg;
        end
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // First class to visit: scored if trained, else skipped by compare step
    function automatic state_t S_CMP_ENTRY();
        S_CMP_ENTRY = trained_reg[0] ? S_DIFF : S_CMP;
    endfunction

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept && op == OP_QUERY && last_element)
                    state_next = S_CMP_ENTRY();
            S_DIFF:  state_next = S_DWAIT;
            S_DWAIT: state_next = last_i ? S_MROW : S_DIFF;
            S_MROW:  state_next = S_MWAIT;
            S_MWAIT:
                if (ph_reg)
                    state_next = !last_j ? S_MROW : (S_TSUM);
            S_TSUM:  state_next = S_TWAIT;
            S_TWAIT:
                if (ph_reg)
                    state_next = last_i ? S_CRIT : S_MROW;
            S_CRIT:  state_next = S_CMP;
            S_CMP:
                if (last_c)
                    state_next = S_OUT;
                else
                    state_next = trained_reg[cls_reg + CW'(1)] ? S_DIFF : S_CMP;
            S_OUT:
                if (out_load)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign best_class  = out_class_reg;
    assign any_trained = out_found_reg;
endmodule

### hw/rtl/qda_checker.sv
// Port-level checker for the QDA classifier, bound to the top level.
// Depends on qda_pkg and the top-level ports.
module qda_props (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [2:0] op,
    input logic       last_element,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] best_class,
    input logic       any_trained
);
    import qda_pkg::*;

    // Handshake outputs never unknown out of reset
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_ready, out_valid})) else $error("unknown handshake");
    // A classify request blocks the input on the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && op == OP_QUERY && last_element |=> !in_ready)
        else $error("ready right after classify request");
    // Result holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(best_class)
            && $stable(any_trained)) else $error("result changed while stalled");
    // No trained class reports class 0
    a_none: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !any_trained |-> best_class == 4'd0) else $error("bad class");
endmodule

bind qda_classifier_inference qda_props u_qda_props (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .last_element(last_element),
    .out_valid(out_valid), .out_ready(out_ready),
    .best_class(best_class), .any_trained(any_trained)
);

### dv/qda_checker.sv
// Checker for the QDA classifier: watches config writes and both item channels,
// scores each classify request in a bit-true predictor and compares the result.
// Depends on qda_pkg.
`timescale 1ns / 1ps
module qda_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  op,
    input  logic [3:0]  class_id,
    input  logic [2:0]  row_index,
    input  logic [2:0]  col_index,
    input  logic signed [31:0] value,
    input  logic        last_element,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [3:0]  best_class,
    input  logic        any_trained,
    output int          fail_count,
    output int          pending
);
    import qda_pkg::*;

    typedef struct packed {
        logic [3:0] cls;
        logic       found;
    } verdict_t;

    logic [1:0]        mode_q;
    logic [4:0]        classes_q;
    logic [3:0]        features_q;
    logic signed [63:0] mean_m [16][8];
    logic signed [63:0] icov_m [16][8][8];
    logic signed [63:0] logsz_m [16];
    logic signed [63:0] logdet_m [16];
    logic              trained_m [16];
    logic signed [63:0] query_m [8];
    verdict_t          verdict_q[$];

    function automatic logic signed [63:0] clip32(logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // arithmetic shift is floor division by 2^16
    function automatic logic signed [63:0] fl16(logic signed [63:0] v);
        return v >>> 16;
    endfunction

    function automatic logic signed [63:0] mahal_dist(int c, int n);
        logic signed [63:0] d [8];
        logic signed [63:0] t;
        logic signed [63:0] acc;
        acc = 0;
        for (int i = 0; i < n; i++) d[i] = clip32(query_m[i] - mean_m[c][i]);
        for (int i = 0; i < n; i++)
        begin
            t = 0;
            for (int j = 0; j < n; j++) t += fl16(icov_m[c][i][j] * d[j]);
            t = clip32(t);
            acc += fl16(d[i] * t);
        end
        return acc;
    endfunction

    function automatic verdict_t classify();
        verdict_t r;
        int nc, nf;
        logic signed [63:0] dsum, score, top;
        r = '0;
        top = 0;
        nc = (classes_q < 1) ? 1 : (classes_q > 16) ? 16 : classes_q;
        nf = (features_q < 1) ? 1 : (features_q > 8) ? 8 : features_q;
        for (int c = 0; c < nc; c++)
        begin
            if (!trained_m[c]) continue;
            dsum = mahal_dist(c, nf);
            case (mode_q)
                MODE_FULL:    score = logsz_m[c] - logdet_m[c] - dsum;
                MODE_UNIFORM: score = -logdet_m[c] - dsum;
                MODE_MAHAL:   score = -dsum;
                default:      score = 0;
            endcase
            if (!r.found || score > top)
            begin
                r.found = 1'b1;
                r.cls = c[3:0];
                top = score;
            end
        end
        return r;
    endfunction

    assign pending = verdict_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t e;
        if (!rst_n)
        begin
            mode_q <= MODE_FULL;
            classes_q <= 5'd2;
            features_q <= 4'd1;
            for (int c = 0; c < 16; c++) trained_m[c] = 1'b0;
            fail_count <= 0;
            verdict_q.delete();
        end
        else
        begin
            // config writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE:     mode_q <= cfg_data[1:0];
                    CFG_CLASSES:  classes_q <= cfg_data;
                    CFG_FEATURES: features_q <= cfg_data[3:0];
                    default: ;
                endcase
            end
            // accepted input item
            if (in_valid && in_ready)
            begin
                case (op)
                    OP_MEAN:   mean_m[class_id][row_index] = value;
                    OP_INVCOV: icov_m[class_id][row_index][col_index] = value;
                    OP_LOGSZ:  logsz_m[class_id] = value;
                    OP_LOGDET: logdet_m[class_id] = value;
                    OP_TRAIN:  trained_m[class_id] = (value != 0);
                    OP_QUERY:
                    begin
                        query_m[row_index] = value;
                        if (last_element) verdict_q.push_back(classify());
                    end
                    default: ;
                endcase
            end
            // accepted result item
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("unexpected result item best_class=%0d", best_class);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = verdict_q.pop_front();
                    if (best_class !== e.cls || any_trained !== e.found)
                    begin
                        if (best_class !== e.cls)
                            $error("best_class expected %0d actual %0d", e.cls, best_class);
                        if (any_trained !== e.found)
                            $error("any_trained expected %0d actual %0d",
                                   e.found, any_trained);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

### dv/tb_top.sv
// Stimulus and verdict for the QDA classifier: parameter loads, query vectors
// and register phases with random gaps. Depends on qda_pkg and qda_checker.
`timescale 1ns / 1ps
module tb_top;
    import qda_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [4:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  op;
    logic [3:0]  class_id;
    logic [2:0]  row_index;
    logic [2:0]  col_index;
    logic signed [31:0] value;
    logic        last_element;
    logic        out_valid;
    logic        out_ready;
    logic [3:0]  best_class;
    logic        any_trained;
    int          fail_count;
    int          pending;
    int          nf_cur;

    qda_classifier_inference u_dut (.*);
    qda_checker u_chk (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
        endcase
    endfunction

    // valid stays high across back-to-back items, drops only for a gap
    task automatic send(input logic [2:0] o, input int c, input int r, input int k,
                        input logic signed [31:0] v, input logic l);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        class_id <= c[3:0];
        row_index <= r[2:0];
        col_index <= k[2:0];
        value <= v;
        last_element <= l;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input int d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d[4:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // full parameter set of one class; all 16 are loaded so no unwritten reads occur
    task automatic load_class(input int c);
        for (int i = 0; i < 8; i++)
            send(OP_MEAN, c, i, $urandom_range(0, 7), rand_val(),
                 1'($urandom_range(0, 1)));
        for (int i = 0; i < 8; i++)
            for (int j = 0; j < 8; j++)
                send(OP_INVCOV, c, i, j, rand_val(), 1'b0);
        send(OP_LOGSZ, c, 0, 0, rand_val(), 1'b0);
        send(OP_LOGDET, c, 0, 0, rand_val(), 1'b0);
    endtask

    task automatic query(input int n);
        for (int i = 0; i < n; i++)
            send(OP_QUERY, $urandom_range(0, 15), i, $urandom_range(0, 7), rand_val(),
                 i == n - 1);
    endtask

    // output side stalls
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 9) == 0);

    initial
    begin
        #400ms;
        $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data = '0;
        in_valid = 1'b0;
        op = OP_MEAN;
        class_id = '0;
        row_index = '0;
        col_index = '0;
        value = '0;
        last_element = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no trained class, then load everything, zero features beyond query
        query(8);
        for (int c = 0; c < 16; c++) load_class(c);
        send(OP_RSVD0, 3, 2, 1, 32'sh7fffffff, 1'b1);
        send(OP_RSVD1, 0, 0, 0, 32'sh80000000, 1'b1);
        send(OP_TRAIN, 1, 0, 0, 32'sh00000001, 1'b1);
        query(8);
        send(OP_TRAIN, 0, 0, 0, 32'sh80000000, 1'b0);
        query(1);
        drain();

        nf_cur = 1;
        for (int ph = 0; ph < 12; ph++)
        begin
            drain();
            cfg_write(CFG_MODE, (ph < 4) ? ph : $urandom_range(0, 3));
            cfg_write(CFG_CLASSES, (ph == 0) ? 0 : (ph == 1) ? 31 : (ph == 2) ? 16 :
                      (ph == 3) ? 1 : $urandom_range(0, 31));
            nf_cur = (ph == 0) ? 8 : (ph == 1) ? 0 : (ph == 2) ? 15 :
                     $urandom_range(1, 8);
            cfg_write(CFG_FEATURES, nf_cur);
            nf_cur = (nf_cur < 1) ? 1 : (nf_cur > 8) ? 8 : nf_cur;
            for (int it = 0; it < 62; it++)
            begin
                case ($urandom_range(0, 9))
                    0, 1: send(OP_TRAIN, $urandom_range(0, 15), 0, 0,
                               $urandom_range(0, 2) ? $urandom() : 0,
                               1'($urandom_range(0, 1)));
                    2: send(3'($urandom_range(OP_MEAN, OP_LOGDET)), $urandom_range(0, 15),
                            $urandom_range(0, 7), $urandom_range(0, 7), rand_val(),
                            1'($urandom_range(0, 1)));
                    3: send($urandom_range(0, 1) ? OP_RSVD1 : OP_RSVD0,
                            $urandom_range(0, 15), $urandom_range(0, 7),
                            $urandom_range(0, 7), rand_val(), 1'b1);
                    default:
                    begin
                        query(nf_cur);
                        it += nf_cur - 1;
                    end
                endcase
            end
        end
        drain();
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
